// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the mipmap downsampler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define AAMD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define AAMD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/aamd_pkg.sv =====
// Package of constants, types and helpers for the mipmap downsampler.
`default_nettype none

package aamd_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int CHAN_W     = 8;
  localparam int WIDTH_W    = 11;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EFF_W      = COL_W + 1;
  localparam int BANK_DEPTH = MAX_WIDTH / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  // Sum of four 8-bit channels.
  localparam int SUM_W      = CHAN_W + 2;

  // x / 3 == (x * 683) >> 11 for every x up to 765.
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_MUL_W = 10;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = SUM_W + DIV3_MUL_W;

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = '1;

  typedef struct packed {
    logic [CHAN_W-1:0] alpha;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  // Clear bit 0, then clamp to the range 2 .. MAX_WIDTH.
  function automatic logic [EFF_W-1:0] eff_width(logic [WIDTH_W-1:0] w_reg);
    logic [WIDTH_W-1:0] w_even;
    logic [EFF_W-1:0]   w;
    w_even = {w_reg[WIDTH_W-1:1], 1'b0};
    if (w_even < WIDTH_W'(2)) begin
      w = EFF_W'(2);
    end else if (32'(w_even) > MAX_WIDTH) begin
      w = EFF_W'(MAX_WIDTH);
    end else begin
      w = EFF_W'(w_even);
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/aamd_if.sv =====
// Stream interfaces for source pixels and downsampled pixels.
`default_nettype none

interface aamd_pixel_if
  import aamd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              frame_start;
  logic [CHAN_W-1:0] pixel_red;
  logic [CHAN_W-1:0] pixel_green;
  logic [CHAN_W-1:0] pixel_blue;
  logic [CHAN_W-1:0] pixel_alpha;

  modport source (
    output valid, frame_start, pixel_red, pixel_green, pixel_blue, pixel_alpha,
    input  ready
  );
  modport sink (
    input  valid, frame_start, pixel_red, pixel_green, pixel_blue, pixel_alpha,
    output ready
  );
endinterface

interface aamd_mip_if
  import aamd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] out_red;
  logic [CHAN_W-1:0] out_green;
  logic [CHAN_W-1:0] out_blue;
  logic [CHAN_W-1:0] out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/alpha_aware_mipmap_downsample.sv =====
// Top level of the alpha-aware 2x2 mipmap downsampler.
`default_nettype none
`include "assert_macros.svh"

// Takes RGBA8 pixels of one source image in raster order, one request per
// clock, and returns one pixel of the half-size image for every 2x2 block,
// at the odd column of each odd row. Throughput is one pixel per clock; the
// result of a block passes the filter stage, then the result register. The
// input stalls only when the filter stage and the result register are both
// full and the result is not taken. Even rows go to a line buffer of
// MAX_WIDTH entries split into an even-column and an odd-column bank, each
// with one write and one registered read port, so the two upper neighbors
// come out together. The buffer is not cleared after reset: each entry
// is valid once the current frame has written it. Mark the first pixel of
// each image with frame_start. Write image_width only while the block is
// idle; it is forced even and clamped to 2 .. MAX_WIDTH.
module alpha_aware_mipmap_downsample
  import aamd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_enable,
  input  logic [WIDTH_W-1:0] cfg_write_data,
  aamd_pixel_if.sink         pixel_in,
  aamd_mip_if.source         pixel_out
);

  // Configuration and position state.
  logic [WIDTH_W-1:0] image_width;
  logic [COL_W-1:0]   column_count;
  logic               odd_row;
  pixel_t             left_hold;

  // Request decode.
  pixel_t             px_in;
  logic               accept;
  logic               advance_out;
  logic [COL_W-1:0]   col_cur;
  logic               odd_cur;
  logic [EFF_W-1:0]   col_inc;
  logic [EFF_W-1:0]   eff_w;
  logic               row_end;
  logic               emit_now;
  logic [BANK_AW-1:0] bank_addr;

  // Line buffer banks and their registered reads.
  pixel_t             bank_even [BANK_DEPTH];
  pixel_t             bank_odd  [BANK_DEPTH];
  pixel_t             rd_even;
  pixel_t             rd_odd;

  // Filter stage and result register.
  logic               b_valid;
  pixel_t             b_left;
  pixel_t             b_cur;
  pixel_t             res;
  logic               o_valid;
  pixel_t             o_pix;

  // Filter datapath.
  pixel_t             quad [4];
  logic [3:0]         opaque;
  logic [2:0]         n_op;
  logic [SUM_W-1:0]   sum_all [4];
  logic [SUM_W-1:0]   sum_op  [3];
  logic [PROD_W-1:0]  prod3   [3];

  assign px_in = '{alpha: pixel_in.pixel_alpha, blue: pixel_in.pixel_blue,
                   green: pixel_in.pixel_green, red: pixel_in.pixel_red};

  // The filter stage moves on when the result register is free or drained;
  // a new request enters whenever the filter stage will be free.
  assign advance_out    = !o_valid || pixel_out.ready;
  assign pixel_in.ready = !b_valid || advance_out;
  assign accept         = pixel_in.valid && pixel_in.ready;

  // A frame mark restarts at column 0 of an even row before the pixel lands.
  assign col_cur   = pixel_in.frame_start ? '0 : column_count;
  assign odd_cur   = pixel_in.frame_start ? 1'b0 : odd_row;
  assign col_inc   = EFF_W'(col_cur) + EFF_W'(1);
  assign eff_w     = eff_width(image_width);
  assign row_end   = col_inc >= eff_w;
  assign emit_now  = odd_cur && col_cur[0];
  assign bank_addr = col_cur[COL_W-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(64);
      column_count <= '0;
      odd_row      <= 1'b0;
      left_hold    <= '0;
      b_valid      <= 1'b0;
      o_valid      <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        image_width <= cfg_write_data;
      end
      if (accept) begin
        if (row_end) begin
          column_count <= '0;
          odd_row      <= !odd_cur;
        end else begin
          column_count <= col_inc[COL_W-1:0];
          odd_row      <= odd_cur;
        end
        // Hold the left pixel of the lower row until its partner arrives.
        if (odd_cur && !col_cur[0]) begin
          left_hold <= px_in;
        end
      end
      if (accept) begin
        b_valid <= emit_now;
      end else if (advance_out) begin
        b_valid <= 1'b0;
      end
      if (advance_out) begin
        o_valid <= b_valid;
      end
    end
  end

  // Even rows write the bank of their column parity; odd rows read both.
  always_ff @(posedge clk) begin
    if (accept && !odd_cur && !col_cur[0]) begin
      bank_even[bank_addr] <= px_in;
    end
    if (accept && emit_now) begin
      rd_even <= bank_even[bank_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !odd_cur && col_cur[0]) begin
      bank_odd[bank_addr] <= px_in;
    end
    if (accept && emit_now) begin
      rd_odd <= bank_odd[bank_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit_now) begin
      b_left <= left_hold;
      b_cur  <= px_in;
    end
    if (advance_out && b_valid) begin
      o_pix <= res;
    end
  end

  // 2x2 reduction: plain box filter when all four are opaque, else average
  // the colors of two or three opaque pixels and force alpha; else zero.
  always_comb begin
    quad[0] = rd_even;
    quad[1] = rd_odd;
    quad[2] = b_left;
    quad[3] = b_cur;
    for (int i = 0; i < 4; i++) begin
      opaque[i] = quad[i].alpha != '0;
    end
    n_op = 3'($countones(opaque));
    for (int k = 0; k < 4; k++) begin
      sum_all[k] = '0;
      for (int i = 0; i < 4; i++) begin
        sum_all[k] = sum_all[k] + SUM_W'(quad[i][CHAN_W*k +: CHAN_W]);
      end
    end
    for (int k = 0; k < 3; k++) begin
      sum_op[k] = '0;
      for (int i = 0; i < 4; i++) begin
        if (opaque[i]) begin
          sum_op[k] = sum_op[k] + SUM_W'(quad[i][CHAN_W*k +: CHAN_W]);
        end
      end
      prod3[k] = PROD_W'(sum_op[k]) * PROD_W'(DIV3_MUL);
    end
    res = '0;
    if (&opaque) begin
      res.red   = sum_all[0][SUM_W-1:2];
      res.green = sum_all[1][SUM_W-1:2];
      res.blue  = sum_all[2][SUM_W-1:2];
      res.alpha = sum_all[3][SUM_W-1:2];
    end else begin
      case (n_op)
        3'd3: begin
          res.red   = prod3[0][DIV3_SHIFT +: CHAN_W];
          res.green = prod3[1][DIV3_SHIFT +: CHAN_W];
          res.blue  = prod3[2][DIV3_SHIFT +: CHAN_W];
          res.alpha = ALPHA_OPAQUE;
        end
        3'd2: begin
          res.red   = sum_op[0][CHAN_W:1];
          res.green = sum_op[1][CHAN_W:1];
          res.blue  = sum_op[2][CHAN_W:1];
          res.alpha = ALPHA_OPAQUE;
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  assign pixel_out.valid     = o_valid;
  assign pixel_out.out_red   = o_pix.red;
  assign pixel_out.out_green = o_pix.green;
  assign pixel_out.out_blue  = o_pix.blue;
  assign pixel_out.out_alpha = o_pix.alpha;

  `AAMD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !b_valid && !o_valid, "pipeline not empty after reset")
  `AAMD_ASSERT(a_block_emits, clk, rst, accept && emit_now |=> b_valid, "completed block lost")
  `AAMD_ASSERT(a_full_stalls, clk, rst, b_valid && o_valid && !pixel_out.ready |-> !pixel_in.ready, "request taken while full")
  `AAMD_ASSERT(a_stage_holds, clk, rst, b_valid && o_valid && !pixel_out.ready |=> b_valid && $stable(b_cur), "filter stage changed while stalled")

endmodule

`default_nettype wire

// ===== tb/alpha_aware_mipmap_downsample_tb.sv =====
// Self-checking testbench of the alpha-aware 2x2 mipmap downsampler.
`timescale 1ns / 100ps

module alpha_aware_mipmap_downsample_tb;
  import aamd_pkg::*;

  localparam int RESET_CYCLES     = 5;
  localparam int WIDTH_AT_RESET   = 64;
  // The result register sits behind the filter stage; allow a margin.
  localparam int PIPE_SETTLE      = 8;
  localparam int LONG_HOLD_CYCLES = 150;
  localparam int STALL_LIMIT      = 2000;
  localparam int RANDOM_PIXELS    = 250;
  localparam int MAX_REPORTS      = 20;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_write_enable;
  logic [WIDTH_W-1:0] cfg_write_data;

  aamd_pixel_if src_bus ();
  aamd_mip_if   mip_bus ();

  alpha_aware_mipmap_downsample i_dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .pixel_in         (src_bus),
    .pixel_out        (mip_bus)
  );

  always #6 clk = ~clk;

  // Downsampled pixels predicted from accepted source requests, oldest first.
  pixel_t pending_mips[$];

  int unsigned pixels_sent;
  int unsigned mips_checked;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  // Random idling on both sides; cleared for the last part of the run.
  bit          idling;
  // Each increment asks the result side for one long hold-off.
  int unsigned long_holds_asked;

  string chan_label [4] = '{"red", "green", "blue", "alpha"};

  // Downsampler state as the testbench tracks it.
  pixel_t             line_store [MAX_WIDTH];
  int                 col_pos;
  bit                 on_odd_row;
  pixel_t             left_px;
  logic [WIDTH_W-1:0] width_reg;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Force the register even, then clamp it to 2 .. MAX_WIDTH.
  function automatic int active_width();
    int w;
    w = int'(width_reg & 11'h7FE);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  // Reduce one 2x2 block. All four visible: plain average of every channel.
  // Two or three visible: average RGB of the visible ones, alpha saturates.
  // Fewer: everything zero.
  function automatic pixel_t box_filter(input pixel_t a, input pixel_t b,
                                        input pixel_t c, input pixel_t d);
    pixel_t quad [4];
    pixel_t res;
    int     sum [4];
    int     opaque;
    quad   = '{a, b, c, d};
    sum    = '{0, 0, 0, 0};
    opaque = 0;
    res    = '0;
    if (a.alpha != 0 && b.alpha != 0 && c.alpha != 0 && d.alpha != 0) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 4; i++) sum[k] += int'(quad[i][8*k +: 8]);
        res[8*k +: 8] = CHAN_W'(sum[k] >> 2);
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        if (quad[i].alpha != 0) begin
          opaque++;
          for (int k = 0; k < 3; k++) sum[k] += int'(quad[i][8*k +: 8]);
        end
      end
      if (opaque > 1) begin
        for (int k = 0; k < 3; k++) res[8*k +: 8] = CHAN_W'(sum[k] / opaque);
        res.alpha = ALPHA_OPAQUE;
      end
    end
    return res;
  endfunction

  // Advance the tracked state by one accepted source pixel.
  task automatic model_pixel(input logic fs, input pixel_t px,
                             output bit has_mip, output pixel_t mip);
    int w;
    w       = active_width();
    has_mip = 1'b0;
    mip     = '0;
    // A frame mark restarts at column 0 of an even row before the pixel lands.
    if (fs) begin
      col_pos    = 0;
      on_odd_row = 1'b0;
    end
    if (!on_odd_row) begin
      line_store[col_pos] = px;
    end else if (col_pos % 2 == 0) begin
      left_px = px;
    end else begin
      mip     = box_filter(line_store[col_pos-1], line_store[col_pos], left_px, px);
      has_mip = 1'b1;
    end
    // A count at or past the width wraps, also right after a width change.
    col_pos++;
    if (col_pos >= w) begin
      col_pos    = 0;
      on_odd_row = !on_odd_row;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic pixel_t rgba(input int r, input int g, input int b, input int a);
    return {CHAN_W'(a), CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
  endfunction

  // Bias alpha toward transparent and opaque so every reduction branch shows up.
  function automatic pixel_t random_pixel();
    pixel_t p;
    p = $urandom;
    case ($urandom_range(0, 9))
      0, 1, 2: p.alpha = '0;
      3, 4:    p.alpha = ALPHA_OPAQUE;
      default: ;
    endcase
    return p;
  endfunction

  // Offer one source request and hold it until the block takes it. Leave
  // valid high on return so back-to-back requests need no second assignment.
  task automatic send_pixel(input logic fs, input pixel_t px);
    bit     has_mip;
    pixel_t mip;
    if (idling && $urandom_range(0, 4) == 0) begin
      src_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    src_bus.valid       <= 1'b1;
    src_bus.frame_start <= fs;
    src_bus.pixel_red   <= px.red;
    src_bus.pixel_green <= px.green;
    src_bus.pixel_blue  <= px.blue;
    src_bus.pixel_alpha <= px.alpha;
    @(posedge clk);
    while (!src_bus.ready) @(posedge clk);
    model_pixel(fs, px, has_mip, mip);
    if (has_mip) pending_mips.push_back(mip);
    pixels_sent++;
  endtask

  // Send random pixels; mark the first one as a frame start when asked.
  task automatic send_run(input int count, input bit fresh);
    for (int n = 0; n < count; n++) send_pixel(fresh && n == 0, random_pixel());
  endtask

  // Drop valid, wait for every predicted result, then let the pipe settle,
  // since the last requests may have produced nothing.
  task automatic wait_mips_drained();
    src_bus.valid <= 1'b0;
    while (pending_mips.size() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  // Write the width register once the block is idle.
  task automatic set_width(input logic [WIDTH_W-1:0] w);
    wait_mips_drained();
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= w;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    width_reg = w;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // One block per reduction case, with channel extremes.
  task automatic test_block_cases();
    pixel_t wide [16];
    pixel_t narrow [8];
    // Width 4, raster order. Blocks: all opaque at 255, all opaque at alpha 1,
    // three visible (765 / 3), two visible next to colored transparent pixels.
    wide = '{
      rgba(255, 0, 128, 255), rgba(255, 255, 0, 255), rgba(3, 0, 0, 1), rgba(0, 1, 0, 1),
      rgba(255, 0, 128, 255), rgba(255, 255, 0, 255), rgba(0, 0, 2, 1), rgba(1, 1, 1, 1),
      rgba(255, 255, 255, 255), rgba(255, 255, 255, 1), rgba(255, 255, 255, 0),
      rgba(100, 51, 0, 37),
      rgba(9, 9, 9, 0), rgba(255, 255, 255, 128), rgba(1, 2, 3, 255), rgba(255, 255, 255, 0)
    };
    // Width 2: a single visible pixel, then none at all.
    narrow = '{
      rgba(255, 255, 255, 255), rgba(255, 255, 255, 0),
      rgba(255, 255, 255, 0), rgba(255, 255, 255, 0),
      rgba(0, 255, 0, 0), rgba(255, 0, 255, 0),
      rgba(128, 64, 32, 0), rgba(0, 0, 0, 0)
    };
    set_width(4);
    for (int i = 0; i < 16; i++) send_pixel(i == 0, wide[i]);
    set_width(2);
    for (int i = 0; i < 8; i++) send_pixel(i == 0, narrow[i]);
    wait_mips_drained();
  endtask

  // Odd and tiny register values; each is forced even, and 0 and 1 are raised to 2.
  task automatic test_width_extremes();
    set_width(0);
    send_run(8, 1'b1);
    set_width(1);
    send_run(8, 1'b1);
    set_width(3);
    send_run(4, 1'b1);
    // Nine runs as eight; three full rows leave the first eight entries written.
    set_width(9);
    send_run(24, 1'b1);
    wait_mips_drained();
  endtask

  // Grow the width inside an odd row so the upper neighbors come from a
  // wider earlier frame, then shrink it past the current column.
  task automatic test_mid_frame_width();
    set_width(4);
    send_run(6, 1'b1);
    set_width(8);
    send_run(6 + 8 + 6, 1'b0);
    set_width(4);
    send_run(1 + 4, 1'b0);
    send_run(8, 1'b1);
    wait_mips_drained();
  endtask

  // Block the result side for a long stretch while requests keep coming.
  task automatic test_sink_backpressure();
    idling = 1'b0;
    set_width(8);
    long_holds_asked++;
    send_run(48, 1'b1);
    wait_mips_drained();
    idling = 1'b1;
  endtask

  // Stop sending mid-frame until every result is in, then resume the frame.
  task automatic test_sender_pause();
    set_width(6);
    send_run(12 + 3, 1'b1);
    wait_mips_drained();
    send_run(3 + 12, 1'b0);
    wait_mips_drained();
  endtask

  // Mostly complete frames of random small widths; some frames are cut
  // short by the next frame mark.
  task automatic test_random_frames();
    int unsigned start_count;
    int          total;
    start_count = pixels_sent;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      // Run the last third with no idling on either side.
      if (pixels_sent - start_count >= 2 * RANDOM_PIXELS / 3) idling = 1'b0;
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       set_width(WIDTH_W'($urandom_range(0, 3)));
          1:       set_width(WIDTH_W'($urandom_range(17, 40)));
          default: set_width(WIDTH_W'(2 * $urandom_range(1, 8)));
        endcase
      end
      total = 2 * $urandom_range(1, 2) * active_width();
      if ($urandom_range(0, 7) == 0) total = $urandom_range(1, total);
      send_run(total, 1'b1);
    end
    wait_mips_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls plus the requested long hold-off
  // ---------------------------------------------------------------------------

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_served;
    stall_left   = 0;
    holds_served = 0;
    mip_bus.ready = 1'b1;
    forever begin
      @(posedge clk);
      if (holds_served != long_holds_asked) begin
        holds_served = long_holds_asked;
        stall_left   = LONG_HOLD_CYCLES;
      end else if (stall_left == 0 && idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 7);
      end
      if (stall_left > 0) begin
        mip_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        mip_bus.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : mip_checker
    pixel_t got;
    pixel_t want;
    if (!rst && mip_bus.valid && mip_bus.ready) begin
      got = {mip_bus.out_alpha, mip_bus.out_blue, mip_bus.out_green, mip_bus.out_red};
      if (pending_mips.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected downsampled pixel, expected none, actual %h", $time, got);
      end else begin
        want = pending_mips.pop_front();
        mips_checked++;
        for (int k = 0; k < 4; k++) begin
          if (got[8*k +: 8] !== want[8*k +: 8]) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: %s mismatch, expected %0d actual %0d", $time,
                       chan_label[k], want[8*k +: 8], got[8*k +: 8]);
          end
        end
      end
    end
  end

  // End the run when no request moves on either side for too long.
  always @(posedge clk) begin : watchdog
    if (rst || (src_bus.valid && src_bus.ready) || (mip_bus.valid && mip_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request accepted for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, pending_mips.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst                 = 1'b1;
    cfg_write_enable    = 1'b0;
    cfg_write_data      = '0;
    src_bus.valid       = 1'b0;
    src_bus.frame_start = 1'b0;
    src_bus.pixel_red   = '0;
    src_bus.pixel_green = '0;
    src_bus.pixel_blue  = '0;
    src_bus.pixel_alpha = '0;
    idling              = 1'b1;
    long_holds_asked    = 0;
    pixels_sent         = 0;
    mips_checked        = 0;
    fail_count          = 0;
    quiet_cycles        = 0;
    col_pos             = 0;
    on_odd_row          = 1'b0;
    left_px             = '0;
    width_reg           = WIDTH_W'(WIDTH_AT_RESET);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_block_cases();
    test_width_extremes();
    test_mid_frame_width();
    test_sink_backpressure();
    test_sender_pause();
    test_random_frames();
    wait_mips_drained();

    $display("Checked %0d downsampled pixels from %0d source pixels;", mips_checked,
             pixels_sent);
    $display("widths 2 to 40 incl. odd and clamped values, mid-frame changes, stalls on both sides.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
